FILE: hdl/u8u7_pkg.sv
// Package for the UTF-8 to modified UTF-7 encoder.
// Holds the queue entry type, the queue depth and the base64 alphabet lookup.
// No dependencies.
package u8u7_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_CHARS   = 8;
   localparam int IDX_W       = $clog2(MAX_CHARS);

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_DASH = 8'h2d;

   // Output characters caused by one request
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [IDX_W-1:0]          last_idx;
      logic                      str_end;
      logic                      bad;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qwrite_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qread_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2c;
      end
      return c;
   endfunction

endpackage

FILE: hdl/u8u7_front.sv
// Front end: UTF-8 decode, validity checks and base64 packing.
// Produces all output characters of one request as a queue entry.
// Depends on u8u7_pkg.
module u8u7_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_string_end,
   input  logic                  q_full,
   output u8u7_pkg::qwrite_type  q_wr
);

   logic [20:0] code_accum_ff, code_accum_in;
   logic [1:0]  bytes_rem_ff, bytes_rem_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic        in_b64_ff, in_b64_in;
   logic [3:0]  left_bits_ff, left_bits_in;
   logic [2:0]  left_cnt_ff, left_cnt_in;
   logic        err_ff, err_in;

   logic        accept;
   logic [3:0]  n;
   logic [u8u7_pkg::MAX_CHARS-1:0][7:0] chars;
   logic        bad;

   assign accept = req_push && !q_full;

   always_comb begin
      logic [7:0]  b;
      logic        second;
      logic        done_cp;
      logic        two_units;
      logic [19:0] v;
      logic [19:0] bits;
      logic [1:0][15:0] unit;
      b             = req_data_byte;
      code_accum_in = code_accum_ff;
      bytes_rem_in  = bytes_rem_ff;
      seq_len_in    = seq_len_ff;
      in_b64_in     = in_b64_ff;
      left_bits_in  = left_bits_ff;
      left_cnt_in   = left_cnt_ff;
      err_in        = err_ff;
      chars         = '0;
      n             = 4'd0;
      bad           = 1'b0;
      done_cp       = 1'b0;
      second        = ({1'b0, bytes_rem_ff} + 3'd1) == seq_len_ff;
      v             = 20'(code_accum_ff - 21'h10000);
      two_units     = 1'b0;
      unit          = '0;
      bits          = '0;

      if (err_ff) begin
         if (req_string_end) begin
            chars[0] = 8'h00;
            n        = 4'd1;
            bad      = 1'b1;
         end
      end else begin
         if (bytes_rem_ff == 2'd0) begin
            if (b < 8'h80) begin
               if (in_b64_ff) begin
                  unique case (left_cnt_ff)
                     3'd2: begin
                        chars[n[2:0]] = u8u7_pkg::b64_char({left_bits_ff[1:0], 4'b0000});
                        n = n + 4'd1;
                     end
                     3'd4: begin
                        chars[n[2:0]] = u8u7_pkg::b64_char({left_bits_ff, 2'b00});
                        n = n + 4'd1;
                     end
                     default: ;
                  endcase
                  chars[n[2:0]] = u8u7_pkg::CHAR_DASH;
                  n = n + 4'd1;
                  in_b64_in    = 1'b0;
                  left_bits_in = '0;
                  left_cnt_in  = '0;
               end
               chars[n[2:0]] = b;
               n = n + 4'd1;
               if (b == u8u7_pkg::CHAR_AMP) begin
                  chars[n[2:0]] = u8u7_pkg::CHAR_DASH;
                  n = n + 4'd1;
               end
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
               code_accum_in = {16'd0, b[4:0]};
               bytes_rem_in  = 2'd1;
               seq_len_in    = 3'd2;
            end else if (b >= 8'he0 && b <= 8'hef) begin
               code_accum_in = {17'd0, b[3:0]};
               bytes_rem_in  = 2'd2;
               seq_len_in    = 3'd3;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
               code_accum_in = {18'd0, b[2:0]};
               bytes_rem_in  = 2'd3;
               seq_len_in    = 3'd4;
            end else begin
               bad = 1'b1;
            end
         end else begin
            if (b[7:6] != 2'b10) begin
               bad = 1'b1;
            end else if (second && seq_len_ff == 3'd3 &&
                         ((code_accum_ff == 21'd0 && b < 8'ha0) ||
                          (code_accum_ff == 21'hd && b >= 8'ha0))) begin
               bad = 1'b1;
            end else if (second && seq_len_ff == 3'd4 &&
                         ((code_accum_ff == 21'd0 && b < 8'h90) ||
                          (code_accum_ff == 21'd4 && b >= 8'h90))) begin
               bad = 1'b1;
            end else begin
               code_accum_in = {code_accum_ff[14:0], b[5:0]};
               bytes_rem_in  = bytes_rem_ff - 2'd1;
               done_cp       = (bytes_rem_in == 2'd0);
            end
         end

         if (done_cp) begin
            if (!in_b64_ff) begin
               chars[n[2:0]] = u8u7_pkg::CHAR_AMP;
               n = n + 4'd1;
               in_b64_in = 1'b1;
            end
            v = 20'(code_accum_in - 21'h10000);
            if (code_accum_in > 21'hffff) begin
               two_units = 1'b1;
               unit[0]   = {6'b110110, v[19:10]};
               unit[1]   = {6'b110111, v[9:0]};
            end else begin
               unit[0]   = code_accum_in[15:0];
            end
            for (int k = 0; k < 2; k++) begin
               if (k == 0 || two_units) begin
                  bits = {left_bits_in, unit[k]};
                  unique case (left_cnt_in)
                     3'd2: begin
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[17:12]);
                        n = n + 4'd1;
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[11:6]);
                        n = n + 4'd1;
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[5:0]);
                        n = n + 4'd1;
                        left_bits_in = 4'd0;
                        left_cnt_in  = 3'd0;
                     end
                     3'd4: begin
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[19:14]);
                        n = n + 4'd1;
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[13:8]);
                        n = n + 4'd1;
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[7:2]);
                        n = n + 4'd1;
                        left_bits_in = {2'b00, bits[1:0]};
                        left_cnt_in  = 3'd2;
                     end
                     default: begin
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[15:10]);
                        n = n + 4'd1;
                        chars[n[2:0]] = u8u7_pkg::b64_char(bits[9:4]);
                        n = n + 4'd1;
                        left_bits_in = bits[3:0];
                        left_cnt_in  = 3'd4;
                     end
                  endcase
               end
            end
            code_accum_in = '0;
            seq_len_in    = '0;
         end

         if (!bad && req_string_end && bytes_rem_in != 2'd0) begin
            bad = 1'b1;
         end

         if (bad) begin
            chars    = '0;
            n        = 4'd1;
            err_in   = !req_string_end;
         end else if (req_string_end && in_b64_in) begin
            unique case (left_cnt_in)
               3'd2: begin
                  chars[n[2:0]] = u8u7_pkg::b64_char({left_bits_in[1:0], 4'b0000});
                  n = n + 4'd1;
               end
               3'd4: begin
                  chars[n[2:0]] = u8u7_pkg::b64_char({left_bits_in, 2'b00});
                  n = n + 4'd1;
               end
               default: ;
            endcase
            chars[n[2:0]] = u8u7_pkg::CHAR_DASH;
            n = n + 4'd1;
         end

         if (bad || req_string_end) begin
            code_accum_in = '0;
            bytes_rem_in  = '0;
            seq_len_in    = '0;
            in_b64_in     = 1'b0;
            left_bits_in  = '0;
            left_cnt_in   = '0;
         end
      end

      if (req_string_end) begin
         code_accum_in = '0;
         bytes_rem_in  = '0;
         seq_len_in    = '0;
         in_b64_in     = 1'b0;
         left_bits_in  = '0;
         left_cnt_in   = '0;
         err_in        = 1'b0;
      end
   end

   always_comb begin
      q_wr.valid          = accept && (n != 4'd0);
      q_wr.entry.chars    = chars;
      q_wr.entry.last_idx = u8u7_pkg::IDX_W'(n - 4'd1);
      q_wr.entry.str_end  = req_string_end;
      q_wr.entry.bad      = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_accum_ff <= '0;
         bytes_rem_ff  <= '0;
         seq_len_ff    <= '0;
         in_b64_ff     <= 1'b0;
         left_bits_ff  <= '0;
         left_cnt_ff   <= '0;
         err_ff        <= 1'b0;
      end else if (accept) begin
         code_accum_ff <= code_accum_in;
         bytes_rem_ff  <= bytes_rem_in;
         seq_len_ff    <= seq_len_in;
         in_b64_ff     <= in_b64_in;
         left_bits_ff  <= left_bits_in;
         left_cnt_ff   <= left_cnt_in;
         err_ff        <= err_in;
      end
   end

endmodule

FILE: hdl/u8u7_queue.sv
// Short queue of character groups between front and back end.
// Depends on u8u7_pkg.
module u8u7_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  u8u7_pkg::qwrite_type  q_wr,
   output logic                  q_full,
   output u8u7_pkg::qread_type   q_rd,
   input  logic                  q_rd_en
);

   u8u7_pkg::entry_type mem_ff [u8u7_pkg::QUEUE_DEPTH];

   logic [u8u7_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8u7_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8u7_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_wr, do_rd;

   assign q_full     = (count_ff == u8u7_pkg::QCNT_W'(u8u7_pkg::QUEUE_DEPTH));
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.entry = mem_ff[rd_ptr_ff];
   assign do_wr      = q_wr.valid && !q_full;
   assign do_rd      = q_rd_en && q_rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == u8u7_pkg::QPTR_W'(u8u7_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + u8u7_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == u8u7_pkg::QPTR_W'(u8u7_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + u8u7_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + u8u7_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - u8u7_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/u8u7_back.sv
// Back end: sends the characters of each queued group one per cycle
// as rsp_pop allows, via a registered result stage. Depends on u8u7_pkg.
module u8u7_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u8u7_pkg::qread_type  q_rd,
   output logic                 q_rd_en,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_run_last,
   output logic                 rsp_string_done,
   output logic                 rsp_bad_utf8
);

   logic [u8u7_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 char_ff, char_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;
   logic                       bad_ff, bad_in;
   logic                       load, is_last;

   assign load    = q_rd.valid && (!valid_ff || rsp_pop);
   assign is_last = (idx_ff == q_rd.entry.last_idx);
   assign q_rd_en = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      bad_in   = bad_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = q_rd.entry.chars[idx_ff];
         last_in  = is_last;
         done_in  = is_last && q_rd.entry.str_end;
         bad_in   = q_rd.entry.bad;
         idx_in   = is_last ? '0 : idx_ff + u8u7_pkg::IDX_W'(1);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
      bad_ff  <= bad_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_string_done = done_ff;
   assign rsp_bad_utf8    = bad_ff;

endmodule

FILE: hdl/utf8_to_modified_utf7_encoder.sv
// Top level of the UTF-8 to modified UTF-7 encoder.
// Depends on u8u7_pkg, u8u7_front, u8u7_queue and u8u7_back.
//
// channel   direction  handshake            payload
// req       in         req_push / req_full  req_data_byte, req_string_end
// rsp       out        rsp_empty / rsp_pop  rsp_out_char, rsp_run_last,
//                                           rsp_string_done, rsp_bad_utf8
//
// A request is taken every cycle while the two-entry group queue has room.
// A request yielding k characters holds the back end's character sequencer
// while it sends them, one character a cycle out of the result register
// as rsp_pop allows; a request yielding none puts no group in the queue.
// Synchronous reset empties the queue and result register and clears decode state.
// A stalled result side fills the queue, then raises req_full.
module utf8_to_modified_utf7_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_string_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_string_done,
   output logic       rsp_bad_utf8
);

   u8u7_pkg::qwrite_type q_wr;
   u8u7_pkg::qread_type  q_rd;
   logic                 q_full;
   logic                 q_rd_en;

   assign req_full = q_full;

   u8u7_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .q_full         (q_full),
      .q_wr           (q_wr)
   );

   u8u7_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_full  (q_full),
      .q_rd    (q_rd),
      .q_rd_en (q_rd_en)
   );

   u8u7_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_rd            (q_rd),
      .q_rd_en         (q_rd_en),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .rsp_bad_utf8    (rsp_bad_utf8)
   );

endmodule

FILE: tb/utf8_to_modified_utf7_encoder_tb.sv
// Testbench for utf8_to_modified_utf7_encoder: directed and random UTF-8 strings, with a
// per-byte model that predicts every modified UTF-7 character and checks them in order.
// Depends on u8u7_pkg and the encoder RTL.
module utf8_to_modified_utf7_encoder_tb;

   localparam int RANDOM_BYTES = 330;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_CYCLES  = 80;
   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";

   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
   } utf8_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       str_done;
      logic       bad;
   } utf7_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_string_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_string_done;
   logic       rsp_bad_utf8;

   // decoder and base64 state of the model
   logic [20:0] cp_acc;
   logic [1:0]  cont_left;
   logic [2:0]  seq_len;
   logic        b64_active;
   logic [3:0]  spare_bits;
   logic [2:0]  spare_cnt;
   logic        err_seen;

   utf8_byte_type utf8_bytes_q[$];
   utf7_char_type utf7_expected[$];
   utf7_char_type step_chars[$];
   logic [7:0] str_bytes[$];

   bit req_taken = 1'b0;
   int bytes_taken = 0;
   int total_bytes = 1 << 30;
   int string_count = 0;
   int chars_checked = 0;
   int invalid_strings = 0;
   int full_stalls = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_started = 1'b0;

   utf8_to_modified_utf7_encoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_string_end  (req_string_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .rsp_bad_utf8    (rsp_bad_utf8)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- model ----------------

   function automatic logic [7:0] b64_at(input logic [5:0] v);
      return B64_ALPHABET[8*(63 - int'(v)) +: 8];
   endfunction

   task automatic add_char(input logic [7:0] ch, input logic bad);
      utf7_char_type c;
      c = '{ch: ch, run_last: 1'b0, str_done: 1'b0, bad: bad};
      if (step_chars.size() < u8u7_pkg::MAX_CHARS) step_chars.push_back(c);
   endtask

   task automatic put_unit(input logic [15:0] unit);
      logic [19:0] acc;
      int cnt;
      acc = {spare_bits, unit};
      cnt = int'(spare_cnt) + 16;
      while (cnt >= 6) begin
         cnt -= 6;
         add_char(b64_at(6'((acc >> cnt) & 20'h3f)), 1'b0);
      end
      spare_cnt  = 3'(cnt);
      spare_bits = 4'(acc & ((20'd1 << cnt) - 20'd1));
   endtask

   task automatic close_run();
      int t;
      t = int'(spare_bits) << (6 - int'(spare_cnt));
      if (spare_cnt != 0) add_char(b64_at(6'(t)), 1'b0);
      add_char(u8u7_pkg::CHAR_DASH, 1'b0);
      b64_active = 1'b0;
      spare_bits = '0;
      spare_cnt  = '0;
   endtask

   task automatic clear_state();
      cp_acc     = '0;
      cont_left  = '0;
      seq_len    = '0;
      b64_active = 1'b0;
      spare_bits = '0;
      spare_cnt  = '0;
      err_seen   = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic is_end);
      logic bad;
      logic second;
      logic [20:0] v;
      utf7_char_type c;
      step_chars.delete();
      bad = 1'b0;
      if (err_seen) begin
         if (is_end) begin
            add_char(8'h00, 1'b1);
            clear_state();
         end
      end else begin
         if (cont_left == 0) begin
            if (b < 8'h80) begin
               if (b64_active) close_run();
               add_char(b, 1'b0);
               if (b == u8u7_pkg::CHAR_AMP) add_char(u8u7_pkg::CHAR_DASH, 1'b0);
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
               cp_acc = 21'(b & 8'h1f); cont_left = 2'd1; seq_len = 3'd2;
            end else if (b >= 8'he0 && b <= 8'hef) begin
               cp_acc = 21'(b & 8'h0f); cont_left = 2'd2; seq_len = 3'd3;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
               cp_acc = 21'(b & 8'h07); cont_left = 2'd3; seq_len = 3'd4;
            end else begin
               bad = 1'b1;
            end
         end else begin
            second = (int'(cont_left) + 1 == int'(seq_len));
            if (b[7:6] != 2'b10) begin
               bad = 1'b1;
            end else if (second && seq_len == 3'd3 &&
                         ((cp_acc == 0 && b < 8'ha0) || (cp_acc == 21'hd && b >= 8'ha0))) begin
               bad = 1'b1;   // overlong or surrogate
            end else if (second && seq_len == 3'd4 &&
                         ((cp_acc == 0 && b < 8'h90) || (cp_acc == 21'h4 && b >= 8'h90))) begin
               bad = 1'b1;   // overlong or beyond U+10FFFF
            end else begin
               cp_acc    = {cp_acc[14:0], b[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 0) begin
                  if (!b64_active) begin
                     add_char(u8u7_pkg::CHAR_AMP, 1'b0);
                     b64_active = 1'b1;
                  end
                  if (cp_acc > 21'hffff) begin
                     v = cp_acc - 21'h10000;
                     put_unit(16'hd800 + 16'(v[19:10]));
                     put_unit(16'hdc00 + 16'(v[9:0]));
                  end else begin
                     put_unit(cp_acc[15:0]);
                  end
                  cp_acc  = '0;
                  seq_len = '0;
               end
            end
         end
         if (!bad && is_end && cont_left != 0) bad = 1'b1;
         if (bad) begin
            step_chars.delete();
            add_char(8'h00, 1'b1);
            clear_state();
            if (!is_end) err_seen = 1'b1;
         end else if (is_end) begin
            if (b64_active) close_run();
            clear_state();
         end
      end
      foreach (step_chars[i]) begin
         c = step_chars[i];
         c.run_last = (i == step_chars.size() - 1);
         c.str_done = c.run_last && is_end;
         if (c.bad && c.str_done) invalid_strings++;
         utf7_expected.push_back(c);
      end
   endtask

   // ---------------- stimulus helpers ----------------

   task automatic add_cp(input int unsigned cp);
      if (cp < 'h80) begin
         str_bytes.push_back(8'(cp));
      end else if (cp < 'h800) begin
         str_bytes.push_back(8'(8'hc0 | (cp >> 6)));
         str_bytes.push_back(8'(8'h80 | (cp & 'h3f)));
      end else if (cp < 'h10000) begin
         str_bytes.push_back(8'(8'he0 | (cp >> 12)));
         str_bytes.push_back(8'(8'h80 | ((cp >> 6) & 'h3f)));
         str_bytes.push_back(8'(8'h80 | (cp & 'h3f)));
      end else begin
         str_bytes.push_back(8'(8'hf0 | (cp >> 18)));
         str_bytes.push_back(8'(8'h80 | ((cp >> 12) & 'h3f)));
         str_bytes.push_back(8'(8'h80 | ((cp >> 6) & 'h3f)));
         str_bytes.push_back(8'(8'h80 | (cp & 'h3f)));
      end
   endtask

   function automatic int unsigned random_cp();
      int unsigned cp;
      case ($urandom_range(9))
         0, 1, 2, 3: cp = ($urandom_range(7) == 0) ? int'(u8u7_pkg::CHAR_AMP)
                                                   : $urandom_range(1, 127);
         4, 5:       cp = $urandom_range('h80, 'h7ff);
         6, 7: begin
            cp = $urandom_range('h800, 'hffff);
            if (cp >= 'hd800 && cp <= 'hdfff) cp = cp ^ 'h4000;
         end
         default:    cp = $urandom_range('h10000, 'h10ffff);
      endcase
      return cp;
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range('h80, 'hbf));
   endfunction

   task automatic add_flaw(output bit cut_short);
      int n;
      cut_short = 1'b0;
      case ($urandom_range(6))
         0: str_bytes.push_back(8'($urandom_range(1, 255)));
         1: str_bytes.push_back($urandom_range(1) ? 8'($urandom_range('h80, 'hc1))
                                                  : 8'($urandom_range('hf5, 'hff)));
         2: begin
            n = str_bytes.size();
            case ($urandom_range(2))
               0:       add_cp($urandom_range('h80, 'h7ff));
               1:       add_cp($urandom_range('h800, 'hd7ff));
               default: add_cp($urandom_range('h10000, 'h10ffff));
            endcase
            repeat ($urandom_range(1, str_bytes.size() - n - 1)) void'(str_bytes.pop_back());
            cut_short = 1'b1;
         end
         3: case ($urandom_range(2))
            0: begin
               str_bytes.push_back(8'($urandom_range('hc0, 'hc1)));
               str_bytes.push_back(cont_byte());
            end
            1: begin
               str_bytes.push_back(8'he0);
               str_bytes.push_back(8'($urandom_range('h80, 'h9f)));
               str_bytes.push_back(cont_byte());
            end
            default: begin
               str_bytes.push_back(8'hf0);
               str_bytes.push_back(8'($urandom_range('h80, 'h8f)));
               str_bytes.push_back(cont_byte());
               str_bytes.push_back(cont_byte());
            end
         endcase
         4: begin
            str_bytes.push_back(8'hed);
            str_bytes.push_back(8'($urandom_range('ha0, 'hbf)));
            str_bytes.push_back(cont_byte());
         end
         5: begin
            str_bytes.push_back(8'hf4);
            str_bytes.push_back(8'($urandom_range('h90, 'hbf)));
            str_bytes.push_back(cont_byte());
            str_bytes.push_back(cont_byte());
         end
         default: begin
            str_bytes.push_back(8'($urandom_range('hc2, 'hf4)));
            str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(1, 127))
                                                  : 8'($urandom_range('hc0, 'hff)));
         end
      endcase
   endtask

   task automatic finish_string();
      utf8_byte_type u;
      foreach (str_bytes[i]) begin
         u = '{data: str_bytes[i], is_end: (i == str_bytes.size() - 1)};
         utf8_bytes_q.push_back(u);
      end
      str_bytes.delete();
      string_count++;
   endtask

   function automatic int idle_phase();
      if (bytes_taken < total_bytes / 3) return 0;
      if (bytes_taken < 2 * total_bytes / 3) return 1;
      return 2;
   endfunction

   task automatic report_mismatch(input utf7_char_type want, input utf7_char_type got,
                                  input bit none_waiting);
      mismatches++;
      if (mismatches <= 10) begin
         if (none_waiting)
            $display("ERROR: unexpected result char=%02h last=%b done=%b bad=%b",
                     got.ch, got.run_last, got.str_done, got.bad);
         else
            $display("ERROR: result %0d exp char=%02h last=%b done=%b bad=%b, got %02h %b %b %b",
                     chars_checked, want.ch, want.run_last, want.str_done, want.bad,
                     got.ch, got.run_last, got.str_done, got.bad);
      end
   endtask

   // ---------------- driver, receiver, monitor ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (utf8_bytes_q.size() != 0 &&
             $urandom_range(99) >= (idle_phase() == 0 ? 37 : idle_phase() == 1 ? 50 : 0)) begin
            req_push       <= 1'b1;
            req_data_byte  <= utf8_bytes_q[0].data;
            req_string_end <= utf8_bytes_q[0].is_end;
            void'(utf8_bytes_q.pop_front());
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // long receiver hold-off midway, so the queue fills and req_full rises
   always @(negedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && bytes_taken >= total_bytes / 2) begin
         hold_left    <= HOLD_CYCLES;
         hold_started <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_left != 0)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= $urandom_range(99) >= (idle_phase() == 0 ? 50 : idle_phase() == 1 ? 37 : 0);
   end

   always @(posedge clock) begin
      utf7_char_type got;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_push && !req_full;
         if (req_push && req_full) full_stalls++;
         if (req_taken) begin
            predict_byte(req_data_byte, req_string_end);
            bytes_taken++;
         end
         if (rsp_pop && !rsp_empty) begin
            got = '{ch: rsp_out_char, run_last: rsp_run_last,
                    str_done: rsp_string_done, bad: rsp_bad_utf8};
            if (utf7_expected.size() == 0) begin
               report_mismatch(got, got, 1'b1);
            end else begin
               if (got !== utf7_expected[0]) report_mismatch(utf7_expected[0], got, 1'b0);
               void'(utf7_expected.pop_front());
            end
            chars_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, utf7_expected.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin : stimulus
      bit cut_short;
      int random_items;
      random_items = 0;
      clear_state();

      str_bytes = {8'h01, u8u7_pkg::CHAR_AMP, 8'h41, 8'h7f};
      finish_string();
      // U+0080, U+FFFF, U+10FFFF in one run, closed by an ampersand
      str_bytes = {8'hc2, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
                   u8u7_pkg::CHAR_AMP};
      finish_string();
      str_bytes = {8'hf0, 8'h90, 8'h80, 8'h80};
      finish_string();
      str_bytes = {8'h80};
      finish_string();
      str_bytes = {8'he0, 8'h80, 8'hff};
      finish_string();
      str_bytes = {8'hed, 8'ha0};
      finish_string();
      str_bytes = {8'hc3};
      finish_string();
      str_bytes = {8'hf4, 8'h90};
      finish_string();

      while (random_items < RANDOM_BYTES) begin
         if ($urandom_range(3) != 0) begin
            repeat ($urandom_range(1, 6)) add_cp(random_cp());
            random_items += str_bytes.size();
         end else begin
            repeat ($urandom_range(0, 3)) add_cp(random_cp());
            add_flaw(cut_short);
            random_items += str_bytes.size();
            if (!cut_short)
               repeat ($urandom_range(0, 4)) str_bytes.push_back(8'($urandom_range(1, 255)));
         end
         finish_string();
      end
      total_bytes = utf8_bytes_q.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (utf8_bytes_q.size() != 0 || req_push) @(posedge clock);
      while (utf7_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d strings (%0d bytes, %0d invalid) into %0d checked characters",
               string_count, bytes_taken, invalid_strings, chars_checked);
      $display("Input stalled on full for %0d cycles, %0d mismatches", full_stalls, mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: utf8_to_modified_utf7_encoder.f
hdl/u8u7_pkg.sv
hdl/u8u7_front.sv
hdl/u8u7_queue.sv
hdl/u8u7_back.sv
hdl/utf8_to_modified_utf7_encoder.sv
tb/utf8_to_modified_utf7_encoder_tb.sv
